// ----- rtl/isn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isn_pkg
// Shared types, widths and start-guess table for the Newton square root.
// ----------------------------------------------------------------------------
package isn_pkg;

  localparam int RAD_W  = 32;
  localparam int ROOT_W = 16;
  localparam int POS_W  = 5;
  localparam int REM_W  = 16;

  typedef logic [RAD_W-1:0]  rad_t;
  typedef logic [ROOT_W-1:0] root_t;
  typedef logic [POS_W-1:0]  pos_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam root_t GUESS_TBL [32] = '{
    16'd1,     16'd2,     16'd2,     16'd4,     16'd5,     16'd8,     16'd11,    16'd16,
    16'd22,    16'd32,    16'd45,    16'd64,    16'd90,    16'd128,   16'd181,   16'd256,
    16'd362,   16'd512,   16'd724,   16'd1024,  16'd1448,  16'd2048,  16'd2896,  16'd4096,
    16'd5792,  16'd8192,  16'd11585, 16'd16384, 16'd23170, 16'd32768, 16'd46340, 16'd65535
  };

  function automatic pos_t lead_one(input rad_t v);
    pos_t pos;
    pos = '0;
    for (int b = 0; b < RAD_W; b++) begin
      if (v[b]) begin
        pos = pos_t'(b);
      end
    end
    return pos;
  endfunction

endpackage

// ----- rtl/isn_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isn_div
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module isn_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  isn_pkg::rad_t       dividend,
  input  isn_pkg::root_t      divisor,
  output isn_pkg::rad_t       quotient,
  output isn_pkg::div_stat_t  stat
);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  isn_pkg::pos_t          cnt_r, cnt_nxt;
  isn_pkg::rad_t          dvd_r, dvd_nxt;
  logic [isn_pkg::REM_W-1:0] rem_r, rem_nxt;
  isn_pkg::root_t         dvs_r, dvs_nxt;
  logic [isn_pkg::REM_W:0]   trial;
  logic [isn_pkg::REM_W+1:0] diff;
  logic                   qbit;

  assign trial = {rem_r, dvd_r[isn_pkg::RAD_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_r};
  assign qbit  = ~diff[isn_pkg::REM_W+1];

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    done_nxt = busy_r && (cnt_r == isn_pkg::pos_t'(isn_pkg::RAD_W - 1));
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[isn_pkg::RAD_W-2:0], qbit};
      rem_nxt = qbit ? diff[isn_pkg::REM_W-1:0] : trial[isn_pkg::REM_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == isn_pkg::pos_t'(isn_pkg::RAD_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = dvd_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ----- rtl/integer_sqrt_newton.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_sqrt_newton
// Integer square root of a 32-bit unsigned value by Newton steps on a shared
// serial divider, seeded from a leading-one table.
//
//  channel | dir | tdata
//  --------+-----+---------------------------------
//  in_     | in  | [31:0] radicand
//  out_    | out | [15:0] root
//
//  Each Newton step is one full pass of the restoring divider plus a
//  turnaround, and steps repeat until the quotient is no smaller than the estimate.
//  A zero radicand skips the divider and goes straight to the done state.
//  in_tready is high only while the sequencer is idle; out_ holds a registered
//  result until transfer, and a stalled result blocks the next finish.
//  Reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module integer_sqrt_newton (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] radicand
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [15:0] root
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  isn_pkg::rad_t          rad_r, rad_nxt;
  isn_pkg::root_t         x_r, x_nxt;
  logic                   out_valid_r, out_valid_nxt;
  isn_pkg::root_t         out_data_r, out_data_nxt;

  logic                   div_start;
  isn_pkg::root_t         div_dvs;
  isn_pkg::rad_t          div_dvd;
  isn_pkg::rad_t          quo;
  isn_pkg::div_stat_t     div_stat;
  isn_pkg::root_t         guess;
  logic                   conv;
  logic [isn_pkg::ROOT_W:0] sum;
  logic                   slot_free;
  logic                   in_xfer;

  assign guess     = isn_pkg::GUESS_TBL[isn_pkg::lead_one(in_tdata)];
  assign conv      = quo >= {{(isn_pkg::RAD_W - isn_pkg::ROOT_W){1'b0}}, x_r};
  assign sum       = {1'b0, x_r} + {1'b0, quo[isn_pkg::ROOT_W-1:0]};
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    rad_nxt       = rad_r;
    x_nxt         = x_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    div_dvs       = sum[isn_pkg::ROOT_W:1];
    div_dvd       = rad_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          rad_nxt = in_tdata;
          if (in_tdata == '0) begin
            x_nxt     = '0;
            state_nxt = ST_DONE;
          end else begin
            x_nxt     = guess;
            div_start = 1'b1;
            div_dvs   = guess;
            div_dvd   = in_tdata;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          if (conv) begin
            if (slot_free) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = x_r;
              state_nxt     = ST_IDLE;
            end else begin
              state_nxt = ST_DONE;
            end
          end else begin
            x_nxt     = sum[isn_pkg::ROOT_W:1];
            div_start = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = x_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rad_r      <= rad_nxt;
    x_r        <= x_nxt;
    out_data_r <= out_data_nxt;
  end

  isn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (quo),
    .stat     (div_stat)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV))
    else $error("divider finished outside a division");

  a_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (state_r == ST_DIV))
    else $error("divider running outside a division");

  a_no_accept_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("second transfer accepted while an item is in flight");

endmodule

// ----- bench/integer_sqrt_newton_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_sqrt_newton_test
// Self-checking bench for the Newton integer square root. A local model
// seeds each radicand from a leading-one table and runs the same truncating
// Newton loop to predict every root. Directed corners come first, then bit
// boundaries, perfect squares and their neighbors, width-scaled and uniform
// random radicands. Random idling on both streams is mixed with a
// back-to-back stretch and a full drain after some of the phases.
// ----------------------------------------------------------------------------
module integer_sqrt_newton_test;

  localparam int          LIMIT_CYCLES = 3_000_000;
  localparam int          LINGER       = 300;
  localparam int          IDLE_PCT     = 7;
  localparam int          MAX_REPORTS  = 10;
  localparam logic [15:0] SEED_TBL [32] = '{
    16'd1,    16'd2,    16'd2,     16'd4,     16'd5,     16'd8,     16'd11,    16'd16,
    16'd22,   16'd32,   16'd45,    16'd64,    16'd90,    16'd128,   16'd181,   16'd256,
    16'd362,  16'd512,  16'd724,   16'd1024,  16'd1448,  16'd2048,  16'd2896,  16'd4096,
    16'd5792, 16'd8192, 16'd11585, 16'd16384, 16'd23170, 16'd32768, 16'd46340, 16'd65535
  };

  typedef struct {
    isn_pkg::rad_t  radicand;
    isn_pkg::root_t root;
  } root_exp_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // [31:0] radicand
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [15:0] root

  root_exp_t   pending_roots[$];
  root_exp_t   head;
  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned radicands_sent = 0;
  int unsigned roots_checked  = 0;
  int unsigned zeros_sent     = 0;
  bit          calm           = 1'b0;

  integer_sqrt_newton DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d roots outstanding", cycle_count,
               pending_roots.size());
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Truncating Newton loop seeded by the highest set bit.
  function automatic isn_pkg::root_t newton_root(input isn_pkg::rad_t v);
    logic [31:0] x;
    logic [31:0] q;
    int          msb;
    if (v == '0) begin
      return '0;
    end
    msb = 0;
    for (int b = 0; b < 32; b++) begin
      if (v[b]) begin
        msb = b;
      end
    end
    x = {16'd0, SEED_TBL[msb]};
    forever begin
      q = v / x;
      if (q >= x) begin
        break;
      end
      x = (x + q) >> 1;
    end
    return isn_pkg::root_t'(x);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      roots_checked++;
      if (pending_roots.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected root %0d at cycle %0d", out_tdata, cycle_count);
        end
      end else begin
        head = pending_roots.pop_front();
        if (out_tdata !== head.root) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("root mismatch: radicand %h expected %0d actual %0d",
                     head.radicand, head.root, out_tdata);
          end
        end
      end
    end
  end

  task automatic send_radicand(input isn_pkg::rad_t v);
    root_exp_t e;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do begin
      @(posedge clk);
    end while (!in_tready);
    e.radicand = v;
    e.root     = newton_root(v);
    pending_roots.push_back(e);
    radicands_sent++;
    if (v == '0) begin
      zeros_sent++;
    end
  endtask

  // Drop valid and hold until every root has come back.
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_roots.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic test_corners;
    isn_pkg::rad_t corners[$];
    corners = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
                32'h0000_0004, 32'h0000_000F, 32'h0000_0010, 32'h0000_0011,
                32'h0000_0018, 32'h0000_0019, 32'h0000_FFFF, 32'h0001_0000,
                32'h3FFF_FFFF, 32'h4000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'hFFFE_0000, 32'hFFFE_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000};
    foreach (corners[i]) begin
      send_radicand(corners[i]);
    end
  endtask

  task automatic test_bit_boundaries;
    for (int b = 0; b < 32; b++) begin
      send_radicand(isn_pkg::rad_t'(64'd1 << b));
      send_radicand(isn_pkg::rad_t'((64'd2 << b) - 1));
    end
  endtask

  task automatic test_squares(input int count);
    logic [31:0] n;
    logic [31:0] sq;
    for (int i = 0; i < count; i++) begin
      n  = $urandom_range(65535);
      sq = n * n;
      send_radicand(sq);
      send_radicand(sq - 1);
      send_radicand(sq + 1);
    end
  endtask

  task automatic test_width_scaled(input int count);
    int            w;
    isn_pkg::rad_t v;
    for (int i = 0; i < count; i++) begin
      w = $urandom_range(32, 1);
      v = $urandom;
      send_radicand(w == 32 ? v : v & ((32'd1 << w) - 1));
    end
  endtask

  task automatic test_uniform(input int count);
    for (int i = 0; i < count; i++) begin
      send_radicand($urandom);
    end
  endtask

  task automatic test_back_to_back(input int count);
    calm = 1'b1;
    for (int i = 0; i < count; i++) begin
      send_radicand($urandom_range(3) == 0 ? isn_pkg::rad_t'($urandom_range(255))
                                           : isn_pkg::rad_t'($urandom));
    end
    drain();
    calm = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corners();
    drain();
    test_bit_boundaries();
    test_squares(200);
    drain();
    test_width_scaled(600);
    test_back_to_back(150);
    test_uniform(450);
    drain();
    repeat (LINGER) @(posedge clk);
    $display("covered %0d radicands (%0d zero) and %0d roots in %0d cycles",
             radicands_sent, zeros_sent, roots_checked, cycle_count);
    $display("corners, bit edges, squares +/-1, scaled and uniform values; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0 && pending_roots.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/isn_pkg.sv
rtl/isn_div.sv
rtl/integer_sqrt_newton.sv
bench/integer_sqrt_newton_test.sv
